### rtl/pfra_pkg.sv
// Package: shared types and constants of the page frame refcount allocator.
package pfra_pkg;

    localparam int unsigned FrameShift = 12;
    localparam logic [7:0] ReservedCount = 8'd100;
    localparam logic [7:0] CountMax = 8'hFF;
    localparam logic [31:0] WriteBitMask = 32'h0000_0002;
    localparam logic [31:0] BaseReset = 32'h0010_0000;

    typedef enum logic [1:0] {
        t_ST_OK = 2'd0,
        t_ST_NO_FREE = 2'd1,
        t_ST_OUT_OF_MAP = 2'd2,
        t_ST_SATURATED = 2'd3
    } t_status;

    typedef enum logic {
        t_OP_ALLOC = 1'b0,
        t_OP_SHARE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic opcode;
        logic [31:0] table_entry;
    } t_req;

    typedef struct packed {
        logic [31:0] frame_address;
        logic [31:0] shared_entry;
        logic [1:0] status;
    } t_rsp;

endpackage

### rtl/pfra_req_if.sv
// Interface: request channel (opcode and table entry).
interface pfra_req_if;
    logic valid;
    logic ready;
    pfra_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/pfra_rsp_if.sv
// Interface: result channel (frame address, shared entry, status).
interface pfra_rsp_if;
    logic valid;
    logic ready;
    pfra_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/pfra_cfg_if.sv
// Interface: configuration write channel for low_mem_base.
interface pfra_cfg_if;
    logic valid;
    logic ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/page_frame_refcount_allocator.sv
// Top level: page frame allocator keeping an 8-bit reference count per frame.
//
//  channel   dir  payload                                   beat when
//  i_req     in   opcode, table_entry                       valid && ready
//  o_rsp     out  frame_address, shared_entry, status       valid && ready
//  i_cfg     in   low_mem_base                              valid && ready
//
// Counts live in one memory, one read port, registered read data.
// Share: the result is output straight after the check step when the entry
// is not above base or is off the map, after the modify step when the count is
// saturated, else after read, modify, write back and a recount of the frame's group.
// Allocate: scans a summary bitmap (one bit per group of 32 frames,
// "group holds a zero count") from the top, one fetch and one check step per
// word, then reads the group's 32 counts top-down, writes the found frame's
// count, recounts the group and outputs; at most ceil(NUM_FRAMES/1024) bitmap
// words are scanned, all of them when no frame is free.
// After reset a clearing pass writes every count and builds the bitmap a word
// per cycle; no request is taken meanwhile.
// One request is in flight at a time; a finished result waits in the output
// step only while the previous result is still held by the sink.
module page_frame_refcount_allocator #(
    parameter int unsigned NUM_FRAMES = 16128,
    parameter int unsigned RESERVED_FRAMES = 896
) (
    input logic i_clk,
    input logic i_rst_n,
    pfra_req_if.sink i_req,
    pfra_rsp_if.source o_rsp,
    pfra_cfg_if.sink i_cfg
);

    localparam int unsigned IdxW = $clog2(NUM_FRAMES);
    localparam int unsigned NumGroups = (NUM_FRAMES + 31) / 32;
    localparam int unsigned GrpW = (NumGroups > 1) ? $clog2(NumGroups) : 1;
    localparam int unsigned NumWords = (NumGroups + 31) / 32;
    localparam int unsigned WrdW = (NumWords > 1) ? $clog2(NumWords) : 1;
    localparam int unsigned ResClip =
        (RESERVED_FRAMES > NUM_FRAMES) ? NUM_FRAMES : RESERVED_FRAMES;
    localparam logic [IdxW:0] LastFrame = (IdxW + 1)'(NUM_FRAMES - 1);
    localparam logic [IdxW:0] ResLimit = (IdxW + 1)'(ResClip);
    localparam logic [IdxW:0] ClrWords = (IdxW + 1)'(NumWords);
    localparam logic [31:0] NumFrames32 = 32'(NUM_FRAMES);

    typedef enum logic [9:0] {
        t_S_CLEAR = 10'b0000000001,
        t_S_IDLE = 10'b0000000010,
        t_S_SREAD = 10'b0000000100,
        t_S_SMOD = 10'b0000001000,
        t_S_ASUM = 10'b0000010000,
        t_S_ASUMCHK = 10'b0000100000,
        t_S_AGRP = 10'b0001000000,
        t_S_AFIN = 10'b0010000000,
        t_S_BMUPD = 10'b0100000000,
        t_S_OUT = 10'b1000000000
    } t_state;

    // Storage
    logic [7:0] r_mem [NUM_FRAMES];
    logic [31:0] r_bmap [NumWords];
    logic [7:0] r_rdata;

    // Control and payload registers
    t_state r_state, n_state;
    logic [31:0] r_base;
    logic [IdxW:0] r_clr, n_clr;
    logic [31:0] r_entry, n_entry;
    logic [IdxW-1:0] r_idx, n_idx;
    logic [WrdW-1:0] r_wrd, n_wrd;
    logic [GrpW-1:0] r_grp, n_grp;
    logic [5:0] r_cnt, n_cnt;
    logic r_found, n_found;
    logic r_grpzero, n_grpzero;
    logic r_bmscan, n_bmscan;
    logic [31:0] r_bmword;
    pfra_pkg::t_rsp r_work, n_work;
    pfra_pkg::t_rsp r_rsp, n_rsp;
    logic r_rsp_valid, n_rsp_valid;

    logic mem_we;
    logic [IdxW-1:0] mem_waddr, mem_raddr;
    logic [7:0] mem_wdata;
    logic bm_we;
    logic [WrdW-1:0] bm_waddr;
    logic [31:0] bm_wdata;
    logic [31:0] bm_init_c;

    logic [31:0] shared_c, diff_c;
    logic [IdxW-1:0] grp_top_c;
    logic [4:0] hi_bit_c;
    logic hi_any_c;

    assign i_req.ready = (r_state == t_S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data = r_rsp;

    assign shared_c = r_entry & ~pfra_pkg::WriteBitMask;
    assign diff_c = shared_c - r_base;

    // highest set bit of the fetched bitmap word
    always_comb begin
        hi_bit_c = '0;
        hi_any_c = 1'b0;
        for (int b = 0; b < 32; b++) begin
            if (r_bmword[b]) begin
                hi_bit_c = 5'(b);
                hi_any_c = 1'b1;
            end
        end
    end

    // bitmap word written during clear: groups holding frames above the reserved range
    always_comb begin
        for (int b = 0; b < 32; b++) begin
            bm_init_c[b] = ((32 * int'(r_clr) + b) < NumGroups) && (ResClip < NUM_FRAMES) &&
                ((32 * int'(r_clr) + b + 1) * 32 > ResClip);
        end
    end

    assign grp_top_c = IdxW'({r_grp, 5'd31} > (GrpW + 5)'(NUM_FRAMES - 1)
        ? (GrpW + 5)'(NUM_FRAMES - 1) : {r_grp, 5'd31});

    // Next state
    always_comb begin
        n_state = r_state;
        n_clr = r_clr;
        n_entry = r_entry;
        n_idx = r_idx;
        n_wrd = r_wrd;
        n_grp = r_grp;
        n_cnt = r_cnt;
        n_found = r_found;
        n_grpzero = r_grpzero;
        n_bmscan = r_bmscan;
        n_work = r_work;
        n_rsp = r_rsp;
        n_rsp_valid = r_rsp_valid;
        mem_we = 1'b0;
        mem_waddr = r_idx;
        mem_wdata = '0;
        mem_raddr = r_idx;
        bm_we = 1'b0;
        bm_waddr = r_wrd;
        bm_wdata = r_bmword;
        if (r_rsp_valid && o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end
        unique case (r_state)
            t_S_CLEAR: begin
                mem_we = 1'b1;
                mem_waddr = r_clr[IdxW-1:0];
                mem_wdata = (r_clr < ResLimit) ? pfra_pkg::ReservedCount : 8'd0;
                if (r_clr < ClrWords) begin
                    bm_we = 1'b1;
                    bm_waddr = WrdW'(r_clr);
                    bm_wdata = bm_init_c;
                end
                n_clr = r_clr + 1'b1;
                if (r_clr == LastFrame) begin
                    n_state = t_S_IDLE;
                end
            end
            t_S_IDLE: begin
                if (i_req.valid) begin
                    n_entry = i_req.data.table_entry;
                    n_work = '0;
                    if (i_req.data.opcode == pfra_pkg::t_OP_SHARE) begin
                        n_state = t_S_SREAD;
                    end else begin
                        n_wrd = WrdW'(NumWords - 1);
                        n_found = 1'b0;
                        n_state = t_S_ASUM;
                    end
                end
            end
            t_S_SREAD: begin
                n_work.shared_entry = shared_c;
                n_idx = diff_c[IdxW+11:12];
                if (shared_c <= r_base) begin
                    n_state = t_S_OUT;
                end else if ((diff_c >> pfra_pkg::FrameShift) >= NumFrames32) begin
                    n_work.status = pfra_pkg::t_ST_OUT_OF_MAP;
                    n_state = t_S_OUT;
                end else begin
                    n_state = t_S_SMOD;
                end
            end
            t_S_SMOD: begin
                // r_rdata valid the cycle after its address
                if (!r_found) begin
                    n_found = 1'b1;
                end else begin
                    n_found = 1'b0;
                    if (r_rdata == pfra_pkg::CountMax) begin
                        n_work.status = pfra_pkg::t_ST_SATURATED;
                        n_state = t_S_OUT;
                    end else begin
                        mem_we = 1'b1;
                        mem_wdata = r_rdata + 8'd1;
                        n_grp = GrpW'(r_idx >> 5);
                        n_wrd = WrdW'(r_idx >> 10);
                        n_bmscan = 1'b0;
                        n_cnt = '0;
                        n_grpzero = 1'b0;
                        n_state = t_S_BMUPD;
                    end
                end
            end
            t_S_ASUM: begin
                n_state = t_S_ASUMCHK;
            end
            t_S_ASUMCHK: begin
                if (hi_any_c) begin
                    n_grp = GrpW'({r_wrd, hi_bit_c});
                    n_idx = IdxW'({r_wrd, hi_bit_c, 5'd0});
                    n_cnt = '0;
                    n_state = t_S_AGRP;
                end else if (r_wrd == '0) begin
                    n_work.status = pfra_pkg::t_ST_NO_FREE;
                    n_state = t_S_OUT;
                end else begin
                    n_wrd = r_wrd - 1'b1;
                    n_state = t_S_ASUM;
                end
            end
            t_S_AGRP: begin
                // read counts of the group top-down, data registered and seen the cycle after its address
                mem_raddr = grp_top_c - IdxW'(r_cnt[4:0]);
                if (r_cnt != '0 && !r_found && r_rdata == 8'd0) begin
                    n_found = 1'b1;
                    n_idx = grp_top_c - IdxW'(r_cnt - 6'd1);
                end
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd32) begin
                    n_state = t_S_AFIN;
                end
            end
            t_S_AFIN: begin
                mem_we = 1'b1;
                mem_wdata = 8'd1;
                n_work.frame_address = r_base + 32'({r_idx, 12'd0});
                n_cnt = '0;
                n_grpzero = 1'b0;
                n_bmscan = 1'b0;
                n_state = t_S_BMUPD;
            end
            t_S_BMUPD: begin
                // recount zeros of group r_grp, then fix its bitmap bit
                mem_raddr = IdxW'({r_grp, r_cnt[4:0]});
                if (r_cnt >= 6'd2 && r_bmscan) begin
                    if (r_rdata == 8'd0) n_grpzero = 1'b1;
                end
                if (r_cnt == 6'd1) n_bmscan = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'd33) begin
                    bm_we = 1'b1;
                    bm_waddr = WrdW'(r_grp >> 5);
                    bm_wdata = r_bmword;
                    bm_wdata[r_grp[4:0]] = n_grpzero;
                    n_found = 1'b0;
                    n_state = t_S_OUT;
                end
            end
            t_S_OUT: begin
                // hand over once the output register is free
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp = r_work;
                    n_rsp_valid = 1'b1;
                    n_state = t_S_IDLE;
                end
            end
            default: n_state = t_S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_S_CLEAR;
            r_clr <= '0;
            r_base <= pfra_pkg::BaseReset;
            r_rsp_valid <= 1'b0;
            r_found <= 1'b0;
            r_bmscan <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            r_rsp_valid <= n_rsp_valid;
            r_found <= n_found;
            r_bmscan <= n_bmscan;
            if (i_cfg.valid) r_base <= i_cfg.data;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_idx <= n_idx;
        r_wrd <= n_wrd;
        r_grp <= n_grp;
        r_cnt <= n_cnt;
        r_grpzero <= n_grpzero;
        r_work <= n_work;
        r_rsp <= n_rsp;
    end

    // Count memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    // Summary bitmap: bit set when a group holds a zero count
    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            r_bmap[bm_waddr] <= bm_wdata;
        end
        r_bmword <= r_bmap[(r_state == t_S_BMUPD) ? WrdW'(r_grp >> 5) : n_wrd];
    end

    // A result is only raised in the output step
    a_rsp_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_rsp_valid) |-> $past(r_state) == t_S_OUT)
        else $error("result raised outside output step");
    // No request is taken while the counts are being cleared
    a_no_take_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == t_S_CLEAR |-> !i_req.ready)
        else $error("request taken during clear");
    // A held result stays stable until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_valid && !o_rsp.ready |=> r_rsp_valid && $stable(r_rsp))
        else $error("result changed while stalled");

endmodule
